/* design/lfia_pkg.sv */
// Shared types and constants for the lowest-free slot ID allocator.
`timescale 1ns / 1ps

package lfia_pkg;

   localparam int REQ_TYPE_W  = 2;
   localparam int CLASS_W     = 4;
   localparam int SLOT_ID_W   = 10;
   localparam int HANDLE_W    = 32;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [1:0] {
      REQ_ASSIGN = 2'd0,
      REQ_DROP   = 2'd1,
      REQ_LOOKUP = 2'd2,
      REQ_NOP    = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      CMD_NONE    = 4'd0,
      CMD_CLEAR   = 4'd1,
      CMD_CAPTURE = 4'd2,
      CMD_META    = 4'd3,
      CMD_FAIL    = 4'd4,
      CMD_ASSIGN  = 4'd5,
      CMD_READ    = 4'd6,
      CMD_LOOKUP  = 4'd7,
      CMD_DROP    = 4'd8,
      CMD_SCAN    = 4'd9,
      CMD_LOAD    = 4'd10
   } cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         cls_ok;
      logic         h_zero;
      logic         full;
      logic         id_in;
      logic         match;
      logic         scan_done;
      logic         clear_last;
      logic         out_busy;
   } status_type;

endpackage

/* design/lowest_free_id_allocator.sv */
// Top level of the per-class lowest-free slot ID allocator.
// Lookups and drops with a wrong handle go from the accepted request beat through the META,
// DECODE, CHECK and RESP states to the registered result beat; requests rejected at decode skip CHECK.
// Assign and drop add a slot scan of one slot per cycle through the slot RAM read port;
// one request is in work at a time.
// After reset the slot store is cleared one entry per cycle, all NUM_CLASSES * 2**clog2(SLOTS)
// entries (16384 with the defaults), and no request beat is taken until that is done.
`timescale 1ns / 1ps

module lowest_free_id_allocator
   import lfia_pkg::*;
#(
   parameter int NUM_CLASSES     = 16,
   parameter int SLOTS_PER_CLASS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // class_index [3:0], slot_id [13:4], object_handle [45:14], zero fill above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type [1:0]
   input  logic [REQ_TYPE_W-1:0]  req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // ok [0], given_slot [10:1], found_handle [42:11], zero fill above
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int RSP_USED_W = 1 + SLOT_ID_W + HANDLE_W;

   cmd_type               cmd;
   status_type            status;
   logic                  rsp_ok;
   logic [SLOT_ID_W-1:0]  rsp_slot;
   logic [HANDLE_W-1:0]   rsp_handle;

   lfia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lfia_dp #(
      .NUM_CLASSES     (NUM_CLASSES),
      .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .in_kind    (req_tuser),
      .in_class   (req_tdata[CLASS_W-1:0]),
      .in_slot_id (req_tdata[CLASS_W+SLOT_ID_W-1:CLASS_W]),
      .in_handle  (req_tdata[CLASS_W+SLOT_ID_W+HANDLE_W-1:CLASS_W+SLOT_ID_W]),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_ok     (rsp_ok),
      .rsp_slot   (rsp_slot),
      .rsp_handle (rsp_handle)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - RSP_USED_W){1'b0}}, rsp_handle, rsp_slot, rsp_ok};

endmodule

/* design/lfia_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lfia_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/lfia_ctrl.sv */
// Controller state machine that sequences the allocator datapath.
`timescale 1ns / 1ps

module lfia_ctrl
   import lfia_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_META   = 7'b0000100,
      S_DECODE = 7'b0001000,
      S_CHECK  = 7'b0010000,
      S_SCAN   = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd = CMD_CLEAR;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd      = CMD_CAPTURE;
               state_in = S_META;
            end
         end
         S_META: begin
            cmd      = CMD_META;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            cmd      = CMD_FAIL;
            state_in = S_RESP;
            if (status.cls_ok) begin
               case (status.kind)
                  REQ_ASSIGN: begin
                     if (!status.h_zero && !status.full) begin
                        cmd      = CMD_ASSIGN;
                        state_in = S_SCAN;
                     end
                  end
                  REQ_DROP: begin
                     if (!status.h_zero && status.id_in) begin
                        cmd      = CMD_READ;
                        state_in = S_CHECK;
                     end
                  end
                  REQ_LOOKUP: begin
                     if (status.id_in) begin
                        cmd      = CMD_READ;
                        state_in = S_CHECK;
                     end
                  end
                  default: begin
                     cmd      = CMD_FAIL;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (status.kind == REQ_LOOKUP) begin
               cmd      = CMD_LOOKUP;
               state_in = S_RESP;
            end else if (status.match) begin
               cmd      = CMD_DROP;
               state_in = S_SCAN;
            end else begin
               cmd      = CMD_FAIL;
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            cmd = CMD_SCAN;
            if (status.scan_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!status.out_busy) begin
               cmd      = CMD_LOAD;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/lfia_dp.sv */
// Datapath: slot store, per-class bookkeeping, slot scanner and result register.
`timescale 1ns / 1ps

module lfia_dp
   import lfia_pkg::*;
#(
   parameter int NUM_CLASSES     = 16,
   parameter int SLOTS_PER_CLASS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [REQ_TYPE_W-1:0] in_kind,
   input  logic [CLASS_W-1:0]    in_class,
   input  logic [SLOT_ID_W-1:0]  in_slot_id,
   input  logic [HANDLE_W-1:0]   in_handle,
   output status_type            status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_ok,
   output logic [SLOT_ID_W-1:0]  rsp_slot,
   output logic [HANDLE_W-1:0]   rsp_handle
);

   localparam int SW    = $clog2(SLOTS_PER_CLASS);
   localparam int CW    = $clog2(SLOTS_PER_CLASS + 1);
   localparam int CLW   = $clog2(NUM_CLASSES);
   localparam int AW    = CLW + SW;
   localparam int DEPTH = NUM_CLASSES * (2 ** SW);
   localparam int CXW   = CLW + CLASS_W;
   localparam int IXW   = CW + SLOT_ID_W;
   localparam int GW    = SW + SLOT_ID_W;

   // Captured request.
   req_kind_type          kind_ff;
   logic [CLW-1:0]        cls_ff;
   logic                  cls_ok_ff;
   logic [SLOT_ID_W-1:0]  id_ff;
   logic [HANDLE_W-1:0]   handle_ff;

   // Working copies of the class bookkeeping and scanner state.
   logic [CW-1:0]         lf_w_ff;
   logic [CW-1:0]         top_w_ff;
   logic [CW-1:0]         scan_ff;
   logic [CW-1:0]         chk_ff;
   logic                  pend_ff;
   logic                  dir_down_ff;
   logic [AW-1:0]         clr_ff;

   logic                  res_ok_ff;
   logic [SLOT_ID_W-1:0]  res_slot_ff;
   logic [HANDLE_W-1:0]   res_handle_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_ok_ff;
   logic [SLOT_ID_W-1:0]  rsp_slot_ff;
   logic [HANDLE_W-1:0]   rsp_handle_ff;

   logic [CXW-1:0]        in_class_ext;
   logic                  in_cls_ok;
   logic [CLW-1:0]        in_cls;
   logic [IXW-1:0]        id_ext;
   logic                  id_in;
   logic [SW-1:0]         id_slot;
   logic [CW-1:0]         id_cw;
   logic [GW-1:0]         lf_ext;
   logic [CW-1:0]         lf_inc;
   logic [CW-1:0]         chk_inc;
   logic                  hit;
   logic                  scan_end;
   logic                  scan_done;
   logic [CW-1:0]         new_lf;
   logic [CW-1:0]         new_top;

   logic                  slot_we;
   logic [AW-1:0]         slot_waddr;
   logic [HANDLE_W-1:0]   slot_wdata;
   logic [AW-1:0]         slot_raddr;
   logic [HANDLE_W-1:0]   slot_rdata;

   logic                  meta_we;
   logic [CLW-1:0]        meta_waddr;
   logic [2*CW-1:0]       meta_wdata;
   logic [2*CW-1:0]       meta_rdata;

   // Class 0 and classes past the configured count are rejected; they read class 0.
   assign in_class_ext = CXW'(in_class);
   assign in_cls_ok    = (in_class != '0) && (in_class_ext < CXW'(NUM_CLASSES));
   assign in_cls       = in_cls_ok ? in_class_ext[CLW-1:0] : '0;

   assign id_ext   = IXW'(id_ff);
   assign id_in    = id_ext < IXW'(top_w_ff);
   assign id_slot  = id_ext[SW-1:0];
   assign id_cw    = id_ext[CW-1:0];
   assign lf_ext   = GW'(lf_w_ff[SW-1:0]);
   assign lf_inc   = lf_w_ff + 1'b1;
   assign chk_inc  = chk_ff + 1'b1;

   // The scanner keeps one read in flight; chk_ff is the slot whose data is back.
   assign hit       = pend_ff && (dir_down_ff ? (slot_rdata != '0) : (slot_rdata == '0));
   assign scan_end  = dir_down_ff ? (scan_ff <= lf_w_ff) : (scan_ff >= top_w_ff);
   assign scan_done = hit || scan_end;
   assign new_lf    = dir_down_ff ? lf_w_ff : (hit ? chk_ff : top_w_ff);
   assign new_top   = dir_down_ff ? (hit ? chk_inc : lf_w_ff) : top_w_ff;

   always_comb begin
      slot_we    = 1'b0;
      slot_waddr = {cls_ff, lf_w_ff[SW-1:0]};
      slot_wdata = handle_ff;
      slot_raddr = {cls_ff, id_slot};
      meta_we    = 1'b0;
      meta_waddr = cls_ff;
      meta_wdata = {new_top, new_lf};
      case (cmd)
         CMD_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            slot_wdata = '0;
            meta_we    = 1'b1;
            meta_waddr = clr_ff[AW-1:SW];
            meta_wdata = '0;
         end
         CMD_ASSIGN: begin
            slot_we = 1'b1;
         end
         CMD_DROP: begin
            slot_we    = 1'b1;
            slot_waddr = {cls_ff, id_slot};
            slot_wdata = '0;
         end
         CMD_SCAN: begin
            slot_raddr = {cls_ff, scan_ff[SW-1:0]};
            meta_we    = scan_done;
         end
         default: begin
            slot_we = 1'b0;
         end
      endcase
   end

   lfia_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   // Per-class {top_used, lowest_free}; read with the class of the incoming beat.
   lfia_ram #(
      .WIDTH (2 * CW),
      .DEPTH (NUM_CLASSES)
   ) u_meta_ram (
      .clock (clock),
      .we    (meta_we),
      .waddr (meta_waddr),
      .wdata (meta_wdata),
      .raddr (in_cls),
      .rdata (meta_rdata)
   );

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_CAPTURE: begin
            kind_ff   <= req_kind_type'(in_kind);
            cls_ff    <= in_cls;
            cls_ok_ff <= in_cls_ok;
            id_ff     <= in_slot_id;
            handle_ff <= in_handle;
         end
         CMD_META: begin
            lf_w_ff  <= meta_rdata[CW-1:0];
            top_w_ff <= meta_rdata[2*CW-1:CW];
         end
         CMD_FAIL: begin
            res_ok_ff     <= 1'b0;
            res_slot_ff   <= '0;
            res_handle_ff <= '0;
         end
         CMD_ASSIGN: begin
            if (top_w_ff <= lf_w_ff) begin
               top_w_ff <= lf_inc;
            end
            scan_ff       <= lf_inc;
            dir_down_ff   <= 1'b0;
            pend_ff       <= 1'b0;
            res_ok_ff     <= 1'b1;
            res_slot_ff   <= lf_ext[SLOT_ID_W-1:0];
            res_handle_ff <= '0;
         end
         CMD_LOOKUP: begin
            res_ok_ff     <= (slot_rdata != '0);
            res_slot_ff   <= '0;
            res_handle_ff <= slot_rdata;
         end
         CMD_DROP: begin
            if (lf_w_ff > id_cw) begin
               lf_w_ff <= id_cw;
            end
            scan_ff       <= top_w_ff - 1'b1;
            dir_down_ff   <= 1'b1;
            pend_ff       <= 1'b0;
            res_ok_ff     <= 1'b1;
            res_slot_ff   <= '0;
            res_handle_ff <= '0;
         end
         CMD_SCAN: begin
            if (scan_done) begin
               lf_w_ff  <= new_lf;
               top_w_ff <= new_top;
            end else begin
               scan_ff <= dir_down_ff ? (scan_ff - 1'b1) : (scan_ff + 1'b1);
               chk_ff  <= scan_ff;
               pend_ff <= 1'b1;
            end
         end
         CMD_LOAD: begin
            rsp_ok_ff     <= res_ok_ff;
            rsp_slot_ff   <= res_slot_ff;
            rsp_handle_ff <= res_handle_ff;
         end
         default: begin
            pend_ff <= pend_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd == CMD_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd == CMD_LOAD) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.kind       = kind_ff;
   assign status.cls_ok     = cls_ok_ff;
   assign status.h_zero     = (handle_ff == '0);
   assign status.full       = (lf_w_ff == CW'(SLOTS_PER_CLASS));
   assign status.id_in      = id_in;
   assign status.match      = (slot_rdata == handle_ff);
   assign status.scan_done  = scan_done;
   assign status.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_ok     = rsp_ok_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_handle = rsp_handle_ff;

endmodule
